// ----- hw/rtl/vpf_pkg.sv -----
`default_nettype none
package vpf_pkg;

    // Command codes carried on the input tuser lane
    localparam logic [2:0] CMD_START = 3'd0;
    localparam logic [2:0] CMD_BOOL  = 3'd1;
    localparam logic [2:0] CMD_BYTE  = 3'd2;
    localparam logic [2:0] CMD_SHORT = 3'd3;
    localparam logic [2:0] CMD_INT   = 3'd4;
    localparam logic [2:0] CMD_FLOAT = 3'd5;
    localparam logic [2:0] CMD_END   = 3'd6;

    // Register indexes on the configuration port
    localparam logic REG_HEAD = 1'b0;
    localparam logic REG_TAIL = 1'b1;

    localparam logic [7:0]  HEAD_RESET = 8'hA5;
    localparam logic [7:0]  TAIL_RESET = 8'h5A;
    localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
    localparam int          MAX_BYTES  = 5;

    // One queued job: the bytes one input item produces
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] data;
        logic [2:0]                count;
        logic                      is_tail;
        logic [15:0]               frame_len;
    } job_t;

endpackage
`default_nettype wire

// ----- hw/rtl/vpf_front.sv -----
`default_nettype none
module vpf_front
    import vpf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_accept,
    input  wire logic [2:0]  in_cmd,
    input  wire logic [31:0] in_value,
    input  wire logic [7:0]  head_byte,
    input  wire logic [7:0]  tail_byte,
    output logic             push,
    output job_t             job
);

    logic        in_frame_reg, in_frame_next;
    logic [2:0]  stage_reg, stage_next;
    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  partial_reg, partial_next;
    logic [7:0]  sum_reg, sum_next;
    logic [15:0] count_reg, count_next;

    logic        flush;
    logic [7:0]  flush_byte;
    logic [7:0]  bool_byte;
    logic [31:0] vmask;
    logic [2:0]  nbytes;
    logic [2:0]  nout;
    logic [16:0] count_sum;

    assign flush      = (pos_reg != 3'd0);
    assign flush_byte = flush ? partial_reg : 8'h00;
    assign bool_byte  = partial_reg | (8'(in_value[0]) << pos_reg);

    always_comb begin
        case (in_cmd)
            CMD_BYTE:  begin nbytes = 3'd1; vmask = {24'h0, in_value[7:0]};  end
            CMD_SHORT: begin nbytes = 3'd2; vmask = {16'h0, in_value[15:0]}; end
            default:   begin nbytes = 3'd4; vmask = in_value;                end
        endcase
    end

    always_comb begin
        in_frame_next = in_frame_reg;
        stage_next    = stage_reg;
        pos_next      = pos_reg;
        partial_next  = partial_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        push          = 1'b0;
        job           = '0;
        nout          = 3'd0;
        count_sum     = 17'd0;
        if (in_accept) begin
            case (in_cmd)
                CMD_START: begin
                    in_frame_next = 1'b1;
                    stage_next    = 3'd0;
                    pos_next      = 3'd0;
                    partial_next  = 8'h00;
                    sum_next      = 8'h00;
                    count_next    = 16'd1;
                    job.data[0]   = head_byte;
                    job.count     = 3'd1;
                    push          = 1'b1;
                end
                CMD_END: begin
                    if (in_frame_reg) begin
                        nout      = flush ? 3'd3 : 3'd2;
                        count_sum = {1'b0, count_reg} + 17'(nout);
                        if (flush) begin
                            job.data[0] = partial_reg;
                            job.data[1] = sum_reg + partial_reg;
                            job.data[2] = tail_byte;
                        end else begin
                            job.data[0] = sum_reg;
                            job.data[1] = tail_byte;
                        end
                        job.count     = nout;
                        job.is_tail   = 1'b1;
                        job.frame_len = count_sum[16] ? COUNT_MAX : count_sum[15:0];
                        push          = 1'b1;
                        in_frame_next = 1'b0;
                        stage_next    = 3'd0;
                        pos_next      = 3'd0;
                        partial_next  = 8'h00;
                        sum_next      = 8'h00;
                        count_next    = 16'd0;
                    end
                end
                CMD_BOOL: begin
                    if (in_frame_reg && (stage_reg <= CMD_BOOL)) begin
                        stage_next = CMD_BOOL;
                        if (pos_reg == 3'd7) begin
                            // byte full: send it and start a fresh one
                            job.data[0]  = bool_byte;
                            job.count    = 3'd1;
                            push         = 1'b1;
                            sum_next     = sum_reg + bool_byte;
                            count_next   = (count_reg == COUNT_MAX) ? COUNT_MAX
                                                                    : count_reg + 16'd1;
                            pos_next     = 3'd0;
                            partial_next = 8'h00;
                        end else begin
                            pos_next     = pos_reg + 3'd1;
                            partial_next = bool_byte;
                        end
                    end
                end
                CMD_BYTE, CMD_SHORT, CMD_INT, CMD_FLOAT: begin
                    if (in_frame_reg && (in_cmd >= stage_reg)) begin
                        nout      = nbytes + 3'(flush);
                        count_sum = {1'b0, count_reg} + 17'(nout);
                        job.data  = flush ? {vmask, partial_reg} : {8'h00, vmask};
                        job.count = nout;
                        push      = 1'b1;
                        sum_next  = sum_reg + flush_byte + vmask[7:0] + vmask[15:8]
                                  + vmask[23:16] + vmask[31:24];
                        count_next   = count_sum[16] ? COUNT_MAX : count_sum[15:0];
                        stage_next   = in_cmd;
                        pos_next     = 3'd0;
                        partial_next = 8'h00;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            stage_reg    <= 3'd0;
            pos_reg      <= 3'd0;
            partial_reg  <= 8'h00;
            sum_reg      <= 8'h00;
            count_reg    <= 16'd0;
        end else begin
            in_frame_reg <= in_frame_next;
            stage_reg    <= stage_next;
            pos_reg      <= pos_next;
            partial_reg  <= partial_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/vpf_queue.sv -----
`default_nettype none
module vpf_queue
    import vpf_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  job_t      push_job,
    input  wire logic pop,
    output job_t      head_job,
    output logic      full,
    output logic      empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t           mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           do_push, do_pop;

    assign full     = (cnt_reg == CW'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/vpf_back.sv -----
`default_nettype none
module vpf_back
    import vpf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  job_t             q_job,
    input  wire logic        q_empty,
    output logic             q_pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             out_frame_end,
    output logic [15:0]      out_frame_len,
    output logic             out_last
);

    job_t       job_reg;
    logic       valid_reg;
    logic [2:0] idx_reg;
    logic       last_byte;
    logic       take;

    assign last_byte = (idx_reg == (job_reg.count - 3'd1));
    assign take      = valid_reg && out_ready;
    assign q_pop     = !q_empty && (!valid_reg || (take && last_byte));

    assign out_valid     = valid_reg;
    assign out_byte      = job_reg.data[idx_reg];
    assign out_last      = last_byte;
    assign out_frame_end = last_byte && job_reg.is_tail;
    assign out_frame_len = out_frame_end ? job_reg.frame_len : 16'd0;

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg <= q_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 3'd0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
            idx_reg   <= 3'd0;
        end else if (take) begin
            if (last_byte) begin
                valid_reg <= 1'b0;
                idx_reg   <= 3'd0;
            end else begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/value_pack_framer_unit.sv -----
// Path: an accepted beat is written into the job queue, and its first output byte is
//   offered once the job has been loaded into the output stage register.
// Throughput: one input beat per cycle while the job queue has room; output runs at one
//   byte per cycle while the receiver is ready, and an item makes 0 to 5 bytes, so the
//   pace is set by the single byte-wide output serializer.
// Reset: aresetn (synchronous, active low) closes any frame, empties the queue and the
//   output stage, and restores head_byte to 0xA5 and tail_byte to 0x5A.
`default_nettype none
module value_pack_framer_unit
    import vpf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    input  wire logic [2:0]  s_tuser,   // [2:0] command
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] out_byte, [23:8] frame_length
    output logic             m_tlast,   // frame_end
    output logic [0:0]       m_tuser,   // [0] last_of_run
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [7:0] head_reg;
    logic [7:0] tail_reg;
    logic       cfg_wr;

    logic       in_accept;
    logic       push;
    job_t       push_job;
    job_t       q_job;
    logic       q_full;
    logic       q_empty;
    logic       q_pop;

    logic [7:0]  out_byte;
    logic [15:0] out_len;
    logic        out_end;
    logic        out_last;

    // APB register file: write in the access phase, read back the selected byte
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = {24'h0, (paddr[2] == REG_TAIL) ? tail_reg : head_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= HEAD_RESET;
            tail_reg <= TAIL_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_HEAD: head_reg <= pwdata[7:0];
                REG_TAIL: tail_reg <= pwdata[7:0];
                default:  begin end
            endcase
        end
    end

    // Accept whenever the job queue has a free slot; results waiting on the output
    // side never block the front while there is room.
    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    // Front: track framing state and turn each beat into a byte job
    vpf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_cmd    (s_tuser),
        .in_value  (s_tdata),
        .head_byte (head_reg),
        .tail_byte (tail_reg),
        .push      (push),
        .job       (push_job)
    );

    // Decouple front and back so each can stall on its own
    vpf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (q_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Back: hand out one byte per beat, next job loads as the last byte leaves
    vpf_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_job         (q_job),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_byte      (out_byte),
        .out_frame_end (out_end),
        .out_frame_len (out_len),
        .out_last      (out_last)
    );

    assign m_tdata    = {out_len, out_byte};
    assign m_tlast    = out_end;
    assign m_tuser[0] = out_last;

    // The tail byte always closes the run of its end command
    a_tail_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tuser[0])
        else $error("tail byte not marked as last of run");

    // Frame length is zero on every non-tail beat
    a_len_only_on_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[23:8] == 16'd0))
        else $error("frame length on a non-tail beat");

    // Nothing is offered right after reset
    a_idle_after_reset: assert property (@(posedge aclk)
        !$past(aresetn) |-> !m_tvalid)
        else $error("output valid right after reset");

    // The queue never refuses a job the front produced
    a_no_lost_job: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full)
        else $error("job pushed into a full queue");

endmodule
`default_nettype wire

// ----- tb/value_pack_framer_unit_tb.sv -----
`timescale 1ns / 100ps
module value_pack_framer_unit_tb;
    import vpf_pkg::*;

    // Long receiver hold-off used to back the block up into its input
    localparam int STALL_LONG   = 300;
    // Cycles without any beat or bus access before the run is declared hung
    localparam int QUIET_LIMIT  = 3000;
    // Extra cycles waited after the last expected byte has been checked
    localparam int DRAIN_CYCLES = 8;

    // One expected output byte with its side fields
    typedef struct packed {
        logic [7:0]  data;
        logic        tail;
        logic [15:0] len;
        logic        last;
    } frame_byte_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] value
    logic [2:0]  s_tuser;   // [2:0] command
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [7:0] out_byte, [23:8] frame_length
    logic        m_tlast;   // frame_end
    logic [0:0]  m_tuser;   // [0] last_of_run
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    value_pack_framer_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Shadow of the configuration and of the framer state
    logic [7:0]  head_cfg    = HEAD_RESET;
    logic [7:0]  tail_cfg    = TAIL_RESET;
    logic        fr_open     = 1'b0;
    logic [2:0]  fr_stage    = CMD_START;
    int          fr_bits     = 0;
    logic [7:0]  fr_partial  = 8'd0;
    logic [7:0]  fr_sum      = 8'd0;
    logic [15:0] fr_count    = 16'd0;

    frame_byte_t expected_bytes[$];
    frame_byte_t run_bytes[$];

    int  fail_count   = 0;
    int  quiet_cycles = 0;
    bit  tx_idling    = 1'b1;
    bit  rx_idling    = 1'b1;
    int  hold_req     = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Frame predictor
    // ------------------------------------------------------------------

    // Append one byte to the current run; body bytes also feed the checksum.
    task automatic emit_byte(input logic [7:0] b, input bit summed);
        frame_byte_t fb;
        fb = '{data: b, tail: 1'b0, len: 16'd0, last: 1'b0};
        if (summed) fr_sum = fr_sum + b;
        if (fr_count != COUNT_MAX) fr_count = fr_count + 16'd1;
        run_bytes.push_back(fb);
    endtask

    // Emit whatever bools are waiting in the partial byte.
    task automatic flush_bools();
        if (fr_bits != 0) begin
            emit_byte(fr_partial, 1'b1);
            fr_bits    = 0;
            fr_partial = 8'd0;
        end
    endtask

    task automatic clear_frame();
        fr_stage   = CMD_START;
        fr_bits    = 0;
        fr_partial = 8'd0;
        fr_sum     = 8'd0;
        fr_count   = 16'd0;
    endtask

    // Work out the bytes one accepted item produces and queue them.
    task automatic predict_item(input logic [2:0] cmd, input logic [31:0] val);
        frame_byte_t fb;
        int          nbytes;
        run_bytes.delete();
        if (cmd == CMD_START) begin
            // a start inside a frame simply abandons it
            fr_open = 1'b1;
            clear_frame();
            emit_byte(head_cfg, 1'b0);
        end else if (cmd > CMD_END || !fr_open) begin
            // unknown command, or nothing open: drop it
        end else if (cmd == CMD_END) begin
            flush_bools();
            emit_byte(fr_sum, 1'b0);
            emit_byte(tail_cfg, 1'b0);
            fb      = run_bytes.pop_back();
            fb.tail = 1'b1;
            fb.len  = fr_count;
            run_bytes.push_back(fb);
            fr_open = 1'b0;
            clear_frame();
        end else if (cmd < fr_stage) begin
            // type out of order: drop it
        end else if (cmd == CMD_BOOL) begin
            if (val[0]) fr_partial[fr_bits] = 1'b1;
            fr_bits  = fr_bits + 1;
            fr_stage = CMD_BOOL;
            if (fr_bits == 8) begin
                emit_byte(fr_partial, 1'b1);
                fr_bits    = 0;
                fr_partial = 8'd0;
            end
        end else begin
            if (cmd == CMD_BYTE) nbytes = 1;
            else if (cmd == CMD_SHORT) nbytes = 2;
            else nbytes = 4;
            flush_bools();
            for (int k = 0; k < nbytes; k++) emit_byte(val[8*k +: 8], 1'b1);
            fr_stage = cmd;
        end
        if (run_bytes.size() > 0) begin
            fb      = run_bytes.pop_back();
            fb.last = 1'b1;
            run_bytes.push_back(fb);
        end
        foreach (run_bytes[i]) expected_bytes.push_back(run_bytes[i]);
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one beat, optionally after an idle burst, and hold it until taken.
    task automatic send_item(input logic [2:0] cmd, input logic [31:0] val);
        int gap;
        if (tx_idling && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom();
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= val;
        do @(posedge aclk); while (!s_tready);
        predict_item(cmd, val);
    endtask

    // Drop valid and wait until the block has nothing left to give.
    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic read_check(input logic idx, input logic [7:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata[7:0] !== want) begin
            $error("register %0d readback: expected %h, actual %h", idx, want, prdata[7:0]);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Setup then access cycle; the register takes the value at the access edge.
    task automatic write_reg(input logic idx, input logic [7:0] val);
        logic [31:0] junk;
        junk    = $urandom();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk[31:8], val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (idx == REG_HEAD) head_cfg = val;
        else tail_cfg = val;
        read_check(idx, val);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial begin : rx_drive
        int hold_seen;
        int k;
        hold_seen = 0;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                k = STALL_LONG;
            end else if (rx_idling && $urandom_range(0, 7) == 0) begin
                k = $urandom_range(1, 18);
            end else begin
                k = 0;
            end
            if (k != 0) begin
                m_tready <= 1'b0;
                repeat (k) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    // ------------------------------------------------------------------
    // Output checker: every beat against the oldest expected byte
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_beat
        frame_byte_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_bytes.size() == 0) begin
                $error("unexpected beat: out_byte %h frame_end %b", m_tdata[7:0], m_tlast);
                fail_count++;
            end else begin
                want = expected_bytes.pop_front();
                if (m_tdata[7:0] !== want.data) begin
                    $error("out_byte: expected %h, actual %h", want.data, m_tdata[7:0]);
                    fail_count++;
                end
                if (m_tlast !== want.tail) begin
                    $error("frame_end: expected %b, actual %b", want.tail, m_tlast);
                    fail_count++;
                end
                if (m_tdata[23:8] !== want.len) begin
                    $error("frame_length: expected %0d, actual %0d", want.len, m_tdata[23:8]);
                    fail_count++;
                end
                if (m_tuser[0] !== want.last) begin
                    $error("last_of_run: expected %b, actual %b", want.last, m_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_register_defaults();
        read_check(REG_HEAD, HEAD_RESET);
        read_check(REG_TAIL, TAIL_RESET);
    endtask

    // Walk every command and every ignore rule with field extremes.
    task automatic test_directed_frame();
        // nothing open yet: both are dropped
        send_item(CMD_BOOL, 32'h0000_0001);
        send_item(CMD_END, 32'hFFFF_FFFF);
        send_item(CMD_START, 32'h0000_0000);
        // eight bools fill one byte; only bit 0 of the value counts
        send_item(CMD_BOOL, 32'h0000_0001);
        send_item(CMD_BOOL, 32'hFFFF_FFFE);
        send_item(CMD_BOOL, 32'hFFFF_FFFF);
        send_item(CMD_BOOL, 32'h0000_0000);
        send_item(CMD_BOOL, 32'h0000_0001);
        send_item(CMD_BOOL, 32'h0000_0001);
        send_item(CMD_BOOL, 32'h8000_0000);
        send_item(CMD_BOOL, 32'h0000_0001);
        // two bools left partial, flushed ahead of the byte
        send_item(CMD_BOOL, 32'h0000_0001);
        send_item(CMD_BOOL, 32'h0000_0001);
        send_item(CMD_BYTE, 32'hFFFF_FF80);
        send_item(CMD_BOOL, 32'h0000_0001);   // out of order
        send_item(3'd7, 32'hFFFF_FFFF);       // unknown command
        send_item(CMD_SHORT, 32'h0000_FFFF);
        send_item(CMD_INT, 32'hFFFF_FFFF);
        send_item(CMD_FLOAT, 32'h0000_0000);
        send_item(CMD_INT, 32'h1234_5678);    // out of order
        send_item(CMD_END, 32'h0000_0000);
        // restart inside a frame, then end with a partial bool byte
        send_item(CMD_START, 32'hFFFF_FFFF);
        send_item(CMD_BOOL, 32'h0000_0001);
        send_item(CMD_START, 32'h0000_0000);
        send_item(CMD_BOOL, 32'h0000_0001);
        send_item(CMD_END, 32'h0000_0000);
    endtask

    // Head and tail at both extremes, including an empty frame.
    task automatic test_config_extremes();
        drain_outputs();
        write_reg(REG_HEAD, 8'h00);
        write_reg(REG_TAIL, 8'hFF);
        send_item(CMD_START, $urandom());
        send_item(CMD_END, $urandom());
        drain_outputs();
        write_reg(REG_HEAD, 8'hFF);
        write_reg(REG_TAIL, 8'h00);
        send_item(CMD_START, $urandom());
        send_item(CMD_FLOAT, 32'h7FC0_0000);
        send_item(CMD_END, $urandom());
        drain_outputs();
    endtask

    // Mostly well-ordered frames with random content, salted with noise.
    task automatic test_random_frames(input int n_items);
        int         sent;
        int         frames;
        int         n_elems;
        logic [2:0] stage;
        logic [2:0] cmd;
        sent   = 0;
        frames = 0;
        while (sent < n_items) begin
            tx_idling = ($urandom_range(0, 3) != 0);
            rx_idling = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0) begin
                // stray item between frames
                send_item(3'($urandom_range(CMD_BOOL, 7)), $urandom());
                sent++;
            end
            send_item(CMD_START, $urandom());
            sent++;
            stage   = CMD_BOOL;
            n_elems = $urandom_range(0, 12);
            repeat (n_elems) begin
                if ($urandom_range(0, 11) == 0) cmd = 3'($urandom_range(0, 7));
                else if (stage == CMD_BOOL && $urandom_range(0, 2) != 0) cmd = CMD_BOOL;
                else cmd = 3'(stage + $urandom_range(0, CMD_FLOAT - stage));
                if (cmd == CMD_START) stage = CMD_BOOL;
                else if (cmd <= CMD_FLOAT && cmd > stage) stage = cmd;
                send_item(cmd, $urandom());
                sent++;
            end
            // now and then leave the frame open for the next start to abandon
            if ($urandom_range(0, 9) != 0) begin
                send_item(CMD_END, $urandom());
                sent++;
            end
            frames++;
            if (frames % 6 == 0) begin
                drain_outputs();
                write_reg(REG_HEAD, 8'($urandom()));
                write_reg(REG_TAIL, 8'($urandom()));
            end
        end
        drain_outputs();
    endtask

    // Hold the receiver off while the sender keeps offering wide items.
    task automatic test_backpressure();
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        hold_req++;
        send_item(CMD_START, $urandom());
        repeat (12) send_item(CMD_INT, $urandom());
        send_item(CMD_END, $urandom());
        drain_outputs();
    endtask

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 32'd0;
        s_tuser  <= CMD_START;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= 3'd0;
        pwdata   <= 32'd0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_register_defaults();
        test_directed_frame();
        test_config_extremes();
        test_random_frames(365);
        test_backpressure();

        drain_outputs();
        if (fail_count == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
